// ===== src/arpc_pkg.sv =====
// Shared types and constants for the ARP responder with cache.
// No dependencies.
package arpc_pkg;

  localparam logic [2:0] KIND_PACKET = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_PINS   = 3'd2;
  localparam logic [2:0] KIND_PDEL   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1200000;
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_OWN_MAC = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip_addr;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic        is_req;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  frame_op;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_src_mac;
    logic [31:0] frame_src_ip;
    logic [47:0] frame_tgt_mac;
    logic [31:0] frame_tgt_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        status;
  } result_t;

endpackage

// ===== src/arp_responder_with_cache_unit.sv =====
// Top level: APB register file, front queue and back-end engine.
// Depends on arpc_pkg, arpc_front, arpc_back.
// The back end scans the cache table and then the proxy table, one entry per cycle,
// then updates the tables and builds the result; it takes no new transaction until
// that result has been handed over.
// Reset clears both tables' used bits and the registers at once; no sweep.
module arp_responder_with_cache_unit import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16,
  parameter int PROXY_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] target_ip_i,
  input  logic [15:0] op_code_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_valid_o,
  output logic [1:0]  frame_op_o,
  output logic [47:0] frame_dest_mac_o,
  output logic [47:0] frame_src_mac_o,
  output logic [31:0] frame_src_ip_o,
  output logic [47:0] frame_tgt_mac_o,
  output logic [31:0] frame_tgt_ip_o,
  output logic        lookup_hit_o,
  output logic [47:0] lookup_mac_o,
  output logic        status_o
);
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic [31:0] timeout_q;
  logic        qv, qr;
  item_t       qi;
  result_t     res;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
      own_mac_q <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (ridx)
        REG_OWN_IP:  own_ip_q <= pwdata[31:0];
        REG_OWN_MAC: own_mac_q <= pwdata[47:0];
        REG_TIMEOUT: timeout_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (ridx)
      REG_OWN_IP:  prdata = {32'd0, own_ip_q};
      REG_OWN_MAC: prdata = {16'd0, own_mac_q};
      REG_TIMEOUT: prdata = {32'd0, timeout_q};
      default: prdata = '0;
    endcase
  end

  arpc_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .kind_i, .ip_addr_i, .sender_mac_i, .target_ip_i, .op_code_i, .now_ms_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES), .PROXY_ENTRIES(PROXY_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .own_ip_i(own_ip_q), .own_mac_i(own_mac_q), .timeout_i(timeout_q),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign frame_valid_o    = res.frame_valid;
  assign frame_op_o       = res.frame_op;
  assign frame_dest_mac_o = res.frame_dest_mac;
  assign frame_src_mac_o  = res.frame_src_mac;
  assign frame_src_ip_o   = res.frame_src_ip;
  assign frame_tgt_mac_o  = res.frame_tgt_mac;
  assign frame_tgt_ip_o   = res.frame_tgt_ip;
  assign lookup_hit_o     = res.lookup_hit;
  assign lookup_mac_o     = res.lookup_mac;
  assign status_o         = res.status;
endmodule

// ===== src/arpc_front.sv =====
// Front end: accepts input transactions into a two-entry queue.
// Depends on arpc_pkg.
module arpc_front import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] target_ip_i,
  input  logic [15:0] op_code_i,
  input  logic [31:0] now_ms_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      in_d;
  logic       push, pop;

  assign ready_o   = cnt_q != 2'd2;
  assign push      = valid_i && ready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop       = q_valid_o && q_ready_i;
  assign q_item_o  = mem_q[rp_q];

  always_comb begin
    in_d.kind       = kind_i;
    in_d.ip_addr    = ip_addr_i;
    in_d.sender_mac = sender_mac_i;
    in_d.target_ip  = target_ip_i;
    in_d.is_req     = op_code_i == ARP_OP_REQUEST;
    in_d.now_ms     = now_ms_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== src/arpc_back.sv =====
// Back end: sequential cache and proxy table search, update and result build.
// Depends on arpc_pkg.
module arpc_back import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16,
  parameter int PROXY_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  input  logic [31:0] own_ip_i,
  input  logic [47:0] own_mac_i,
  input  logic [31:0] timeout_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);
  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int PW = (PROXY_ENTRIES > 1) ? $clog2(PROXY_ENTRIES) : 1;
  localparam int CCW = $clog2(CACHE_ENTRIES + 1);
  localparam int PCW = $clog2(PROXY_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CSCAN = 3'd1;
  localparam logic [2:0] S_PSCAN = 3'd2;
  localparam logic [2:0] S_DO    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] st_q;
  item_t it_q;
  logic [CACHE_ENTRIES-1:0] cused_q;
  logic [PROXY_ENTRIES-1:0] pused_q;
  logic [31:0] cip_q [CACHE_ENTRIES];
  logic [47:0] cmac_q [CACHE_ENTRIES];
  logic        ccmp_q [CACHE_ENTRIES];
  logic [31:0] cstamp_q [CACHE_ENTRIES];
  logic [31:0] pip_q [PROXY_ENTRIES];

  logic [CCW-1:0] ci_q;
  logic [PCW-1:0] pi_q;
  logic found_q, free_q, old_any_q;
  logic [CW-1:0] fslot_q, freeslot_q, oldslot_q;
  logic [31:0] best_q;
  logic pfound_q, pfree_q;
  logic [PW-1:0] pslot_q, pfreeslot_q;
  logic [31:0] fcand_q;
  result_t res_q;

  logic [CW-1:0] cidx;
  logic [PW-1:0] pidx;
  logic [31:0] age;
  logic [CW-1:0] slot;
  logic [31:0] hit_age;
  logic        fresh;

  assign cidx = ci_q[CW-1:0];
  assign pidx = pi_q[PW-1:0];
  assign age  = it_q.now_ms - cstamp_q[cidx];
  assign slot = found_q ? fslot_q : (free_q ? freeslot_q : oldslot_q);
  assign hit_age = it_q.now_ms - cstamp_q[fslot_q];
  assign fresh = found_q && ccmp_q[fslot_q] && (hit_age < timeout_i);
  assign q_ready_o = st_q == S_IDLE;
  assign res_valid_o = st_q == S_OUT;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cused_q <= '0;
      pused_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (q_valid_i) st_q <= S_CSCAN;
        S_CSCAN: if (ci_q == CCW'(CACHE_ENTRIES - 1)) st_q <= S_PSCAN;
        S_PSCAN: if (pi_q == PCW'(PROXY_ENTRIES - 1)) st_q <= S_DO;
        S_DO: begin
          st_q <= S_OUT;
          case (it_q.kind)
            KIND_PACKET: cused_q[slot] <= 1'b1;
            KIND_LOOKUP: if (!fresh) cused_q[slot] <= 1'b1;
            KIND_PINS: if (!pfound_q && pfree_q) pused_q[pfreeslot_q] <= 1'b1;
            KIND_PDEL: if (pfound_q) pused_q[pslot_q] <= 1'b0;
            KIND_CLEAR: begin
              cused_q <= '0;
              pused_q <= '0;
            end
            default: ;
          endcase
        end
        S_OUT: if (res_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        it_q <= q_item_i;
        ci_q <= '0;
        pi_q <= '0;
        found_q <= 1'b0;
        free_q <= 1'b0;
        old_any_q <= 1'b0;
        best_q <= '0;
        oldslot_q <= '0;
        pfound_q <= 1'b0;
        pfree_q <= 1'b0;
        fcand_q <= q_item_i.kind == KIND_PACKET ? q_item_i.target_ip : q_item_i.ip_addr;
      end
      S_CSCAN: begin
        ci_q <= ci_q + 1'b1;
        if (cused_q[cidx]) begin
          if (!found_q && cip_q[cidx] == it_q.ip_addr) begin
            found_q <= 1'b1;
            fslot_q <= cidx;
          end
          if (!old_any_q || age > best_q) begin
            old_any_q <= 1'b1;
            best_q <= age;
            oldslot_q <= cidx;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
          freeslot_q <= cidx;
        end
      end
      S_PSCAN: begin
        pi_q <= pi_q + 1'b1;
        if (pused_q[pidx]) begin
          if (!pfound_q && pip_q[pidx] == fcand_q) begin
            pfound_q <= 1'b1;
            pslot_q <= pidx;
          end
        end else if (!pfree_q) begin
          pfree_q <= 1'b1;
          pfreeslot_q <= pidx;
        end
      end
      S_DO: begin
        res_q <= '0;
        case (it_q.kind)
          KIND_PACKET: begin
            cip_q[slot] <= it_q.ip_addr;
            cmac_q[slot] <= it_q.sender_mac;
            ccmp_q[slot] <= 1'b1;
            cstamp_q[slot] <= it_q.now_ms;
            if (it_q.is_req && (it_q.target_ip == own_ip_i || pfound_q)) begin
              res_q.frame_valid <= 1'b1;
              res_q.frame_op <= OP_REPLY;
              res_q.frame_dest_mac <= it_q.sender_mac;
              res_q.frame_src_mac <= own_mac_i;
              res_q.frame_src_ip <= it_q.target_ip == own_ip_i ? own_ip_i : it_q.target_ip;
              res_q.frame_tgt_mac <= it_q.sender_mac;
              res_q.frame_tgt_ip <= it_q.ip_addr;
            end
          end
          KIND_LOOKUP: begin
            if (fresh) begin
              res_q.lookup_hit <= 1'b1;
              res_q.lookup_mac <= cmac_q[fslot_q];
            end else begin
              cip_q[slot] <= it_q.ip_addr;
              cmac_q[slot] <= '0;
              ccmp_q[slot] <= 1'b0;
              cstamp_q[slot] <= it_q.now_ms;
              res_q.frame_valid <= 1'b1;
              res_q.frame_op <= OP_REQUEST;
              res_q.frame_dest_mac <= MAC_BCAST;
              res_q.frame_src_mac <= own_mac_i;
              res_q.frame_src_ip <= own_ip_i;
              res_q.frame_tgt_ip <= it_q.ip_addr;
            end
          end
          KIND_PINS: begin
            if (!pfound_q) begin
              if (pfree_q) pip_q[pfreeslot_q] <= it_q.ip_addr;
              else res_q.status <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end
endmodule
